FILE: sv/kis_pkg.sv
// Shared types and codes for the keyed item stack.
// Used by kis_mem, kis_seq, keyed_item_stack and its checker.
package kis_pkg;

	localparam int unsigned FieldW = 8;

	typedef enum logic [1:0] {
		ACT_PUSH   = 2'd0,
		ACT_POP    = 2'd1,
		ACT_DELETE = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic [FieldW-1:0] key;
		logic [FieldW-1:0] row;
		logic [FieldW-1:0] col;
	} entry_t;

	typedef struct packed {
		status_t           status;
		logic [FieldW-1:0] key;
		logic [FieldW-1:0] row;
		logic [FieldW-1:0] col;
	} result_t;

endpackage

FILE: sv/keyed_item_stack.sv
// Keyed item stack top level: sequencer, entry store and result register.
// Depends on kis_pkg, kis_mem and kis_seq.
//
//  channel   | handshake        | payload
//  ----------+------------------+------------------------------------------
//  command   | start / busy     | action, key_char, row_in, col_in
//  result    | done (one cycle) | status, out_key, out_row, out_col
//
// A command is taken on a clock edge with start high and busy low; its result
// shows on done in the cycle after the command's last cycle of work.
// Push and the unused action need no store read. Pop makes one store read.
// Delete scans entries from the top down to the match, then shifts the entries
// above it down one place; not found scans every entry. The store has a single
// read port. Reset empties the stack at once; no sweep.
// Results cannot be stalled; busy is low whenever done is high.
module keyed_item_stack #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 action,
	input  logic [kis_pkg::FieldW-1:0] key_char,
	input  logic [kis_pkg::FieldW-1:0] row_in,
	input  logic [kis_pkg::FieldW-1:0] col_in,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [kis_pkg::FieldW-1:0] out_key,
	output logic [kis_pkg::FieldW-1:0] out_row,
	output logic [kis_pkg::FieldW-1:0] out_col
);
	import kis_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);

	logic          res_vld;
	result_t       res;
	result_t       res_q;
	logic          done_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;
	entry_t        mem_wdata;
	entry_t        mem_rdata;

	kis_seq #(.DEPTH(DEPTH)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.action    (action),
		.key_char  (key_char),
		.row_in    (row_in),
		.col_in    (col_in),
		.busy      (busy),
		.res_vld   (res_vld),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	kis_mem #(.DEPTH(DEPTH)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld) begin
			res_q <= res;
		end
	end

	assign done    = done_q;
	assign status  = res_q.status;
	assign out_key = res_q.key;
	assign out_row = res_q.row;
	assign out_col = res_q.col;

endmodule

FILE: sv/kis_mem.sv
// Entry store: one write port, one read port, read data registered.
// Depends on kis_pkg for the entry type.
module kis_mem #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  kis_pkg::entry_t wdata,
	input  logic [AW-1:0]   raddr,
	output kis_pkg::entry_t rdata
);
	import kis_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: sv/kis_seq.sv
// Sequencer: entry count, pop read, delete scan from the top and gap closing
// shift through the entry store. Depends on kis_pkg.
module kis_seq #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = $clog2(DEPTH),
	parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [1:0]                     action,
	input  logic [kis_pkg::FieldW-1:0]     key_char,
	input  logic [kis_pkg::FieldW-1:0]     row_in,
	input  logic [kis_pkg::FieldW-1:0]     col_in,
	output logic                           busy,
	output logic                           res_vld,
	output kis_pkg::result_t               res,
	output logic                           mem_we,
	output logic [AW-1:0]                  mem_waddr,
	output kis_pkg::entry_t                mem_wdata,
	output logic [AW-1:0]                  mem_raddr,
	input  kis_pkg::entry_t                mem_rdata
);
	import kis_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		POP_WAIT,
		SCAN,
		SHIFT
	} state_t;

	state_t             state_q, state_d;
	logic [CW-1:0]      count_q, count_d;
	logic [AW-1:0]      ptr_q, ptr_d;
	logic [FieldW-1:0]  key_q, key_d;
	logic [CW-1:0]      cnt_m1;
	logic               at_top;
	logic               shift_last;

	assign cnt_m1     = count_q - CW'(1);
	assign at_top     = (CW'(ptr_q) == cnt_m1);
	assign shift_last = ((CW'(ptr_q) + CW'(1)) == cnt_m1);
	assign busy       = (state_q != IDLE);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		ptr_d     = ptr_q;
		key_d     = key_q;
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = '{key: key_char, row: row_in, col: col_in};
		mem_raddr = cnt_m1[AW-1:0];
		res_vld   = 1'b0;
		res       = '{status: ST_OK, key: '0, row: '0, col: '0};

		unique case (state_q)
			IDLE: begin
				if (start) begin
					unique case (action_t'(action))
						ACT_PUSH: begin
							res_vld = 1'b1;
							if (count_q == CW'(DEPTH)) begin
								res.status = ST_FULL;
							end else begin
								mem_we  = 1'b1;
								count_d = count_q + CW'(1);
							end
						end
						ACT_POP: begin
							if (count_q == '0) begin
								res_vld    = 1'b1;
								res.status = ST_EMPTY;
							end else begin
								state_d = POP_WAIT;
							end
						end
						ACT_DELETE: begin
							if (count_q == '0) begin
								res_vld    = 1'b1;
								res.status = ST_EMPTY;
							end else begin
								ptr_d   = cnt_m1[AW-1:0];
								key_d   = key_char;
								state_d = SCAN;
							end
						end
						ACT_NONE: begin
							res_vld = 1'b1;
						end
					endcase
				end
			end
			POP_WAIT: begin
				res_vld = 1'b1;
				res.key = mem_rdata.key;
				res.row = mem_rdata.row;
				res.col = mem_rdata.col;
				count_d = cnt_m1;
				state_d = IDLE;
			end
			SCAN: begin
				// read data belongs to ptr_q; the next lower entry is fetched speculatively
				mem_raddr = ptr_q - AW'(1);
				if (mem_rdata.key == key_q) begin
					if (at_top) begin
						res_vld = 1'b1;
						count_d = cnt_m1;
						state_d = IDLE;
					end else begin
						mem_raddr = ptr_q + AW'(1);
						state_d   = SHIFT;
					end
				end else if (ptr_q == '0) begin
					res_vld    = 1'b1;
					res.status = ST_NOT_FOUND;
					state_d    = IDLE;
				end else begin
					ptr_d = ptr_q - AW'(1);
				end
			end
			SHIFT: begin
				// move entry ptr_q+1 down into ptr_q, prefetch the one above it
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
				mem_wdata = mem_rdata;
				mem_raddr = ptr_q + AW'(2);
				if (shift_last) begin
					res_vld = 1'b1;
					count_d = cnt_m1;
					state_d = IDLE;
				end else begin
					ptr_d = ptr_q + AW'(1);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		key_q <= key_d;
	end

endmodule

FILE: sv/kis_checker.sv
// Port-level checks for keyed_item_stack, bound to the top level.
// Depends on kis_pkg for action and status codes.
module kis_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic [1:0]                 action,
	input logic                       done,
	input logic [1:0]                 status,
	input logic [kis_pkg::FieldW-1:0] out_key,
	input logic [kis_pkg::FieldW-1:0] out_row,
	input logic [kis_pkg::FieldW-1:0] out_col
);
	import kis_pkg::*;

	logic xfer;
	assign xfer = start && !busy;

	// a result transfer always leaves the block ready for the next command
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	a_push_one: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && action == ACT_PUSH) |=> (done && !busy))
		else $error("push result not on next cycle");

	a_pop_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && action == ACT_POP) |=> ((busy && !done) || (done && status == ST_EMPTY)))
		else $error("pop neither read nor reported empty");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (out_key == '0 && out_row == '0 && out_col == '0))
		else $error("nonzero payload on error status");

endmodule

bind keyed_item_stack kis_checker u_kis_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.action  (action),
	.done    (done),
	.status  (status),
	.out_key (out_key),
	.out_row (out_row),
	.out_col (out_col)
);

FILE: verif/keyed_item_stack_tb.sv
// Self-checking testbench for keyed_item_stack: push, pop and delete-by-key traffic.
// Depends on kis_pkg and the keyed_item_stack RTL. A shadow stack predicts each result.
module keyed_item_stack_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import kis_pkg::*;

	localparam int unsigned DEPTH     = 16;
	localparam int unsigned ClkPeriod = 4;
	localparam int unsigned NumRandom = 500;
	localparam int unsigned MaxReport = 10;

	typedef struct {
		action_t           act;
		logic [FieldW-1:0] key;
		logic [FieldW-1:0] row;
		logic [FieldW-1:0] col;
		int unsigned       idle_pct;
	} command_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              start    = 1'b0;
	logic [1:0]        action   = ACT_NONE;
	logic [FieldW-1:0] key_char = '0;
	logic [FieldW-1:0] row_in   = '0;
	logic [FieldW-1:0] col_in   = '0;
	logic              busy;
	logic              done;
	logic [1:0]        status;
	logic [FieldW-1:0] out_key;
	logic [FieldW-1:0] out_row;
	logic [FieldW-1:0] out_col;

	command_t    pending_cmds[$];
	command_t    driven_cmd;
	result_t     expected_results[$];

	entry_t      shadow_entries[DEPTH];
	int unsigned shadow_fill = 0;

	int unsigned cmds_sent     = 0;
	int unsigned results_seen  = 0;
	int unsigned mismatches    = 0;
	int unsigned seen_full     = 0;
	int unsigned seen_empty    = 0;
	int unsigned seen_notfound = 0;

	keyed_item_stack #(
		.DEPTH(DEPTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.action   (action),
		.key_char (key_char),
		.row_in   (row_in),
		.col_in   (col_in),
		.done     (done),
		.status   (status),
		.out_key  (out_key),
		.out_row  (out_row),
		.out_col  (out_col)
	);

	always #(ClkPeriod / 2) clk = ~clk;

	// Apply one command to the shadow stack and return the result it should give.
	function automatic result_t stack_apply(command_t c);
		result_t res;
		int      hit;
		res        = '0;
		res.status = ST_OK;
		hit        = -1;
		case (c.act)
			ACT_PUSH: begin
				if (shadow_fill >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					shadow_entries[shadow_fill] = '{key: c.key, row: c.row, col: c.col};
					shadow_fill++;
				end
			end
			ACT_POP: begin
				if (shadow_fill == 0) begin
					res.status = ST_EMPTY;
				end else begin
					shadow_fill--;
					res.key = shadow_entries[shadow_fill].key;
					res.row = shadow_entries[shadow_fill].row;
					res.col = shadow_entries[shadow_fill].col;
				end
			end
			ACT_DELETE: begin
				if (shadow_fill == 0) begin
					res.status = ST_EMPTY;
				end else begin
					for (int i = int'(shadow_fill) - 1; i >= 0 && hit < 0; i--)
						if (shadow_entries[i].key == c.key)
							hit = i;
					if (hit < 0) begin
						res.status = ST_NOT_FOUND;
					end else begin
						// close the gap, keeping the order of the rest
						for (int j = hit; j + 1 < int'(shadow_fill); j++)
							shadow_entries[j] = shadow_entries[j + 1];
						shadow_fill--;
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic command_t make_cmd(action_t act, logic [7:0] key, logic [7:0] row,
			logic [7:0] col, int unsigned idle_pct);
		command_t c;
		c.act      = act;
		c.key      = key;
		c.row      = row;
		c.col      = col;
		c.idle_pct = idle_pct;
		return c;
	endfunction

	// Driver: predict on each transfer, then present the next command or idle.
	always @(posedge clk) begin
		logic fire;
		fire = start && !busy;
		if (arst_n) begin
			if (fire) begin
				expected_results.push_back(stack_apply(driven_cmd));
				cmds_sent++;
			end
			if (!start || fire) begin
				if (pending_cmds.size() != 0 &&
						$urandom_range(99) >= pending_cmds[0].idle_pct) begin
					driven_cmd = pending_cmds.pop_front();
					start    <= 1'b1;
					action   <= driven_cmd.act;
					key_char <= driven_cmd.key;
					row_in   <= driven_cmd.row;
					col_in   <= driven_cmd.col;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every strobed result must match the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			results_seen++;
			case (status)
				ST_FULL:      seen_full++;
				ST_EMPTY:     seen_empty++;
				ST_NOT_FOUND: seen_notfound++;
				default: ;
			endcase
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MaxReport)
					$display("%0t: unexpected result status=%0d key=%h row=%h col=%h",
						$realtime, status, out_key, out_row, out_col);
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status || out_key !== want.key ||
						out_row !== want.row || out_col !== want.col) begin
					mismatches++;
					if (mismatches <= MaxReport)
						$display("%0t: mismatch exp status=%0d key=%h row=%h col=%h",
							$realtime, want.status, want.key, want.row, want.col,
							" got status=%0d key=%h row=%h col=%h",
							status, out_key, out_row, out_col);
				end
			end
		end
	end

	initial begin
		int unsigned n_real;
		int unsigned push_bias;
		int unsigned stretch;
		int unsigned pct;
		int unsigned pick;
		action_t     act;
		logic [7:0]  key;

		// directed: empty cases, unused code, field extremes, delete positions
		pending_cmds.push_back(make_cmd(ACT_POP, 8'h00, 8'h00, 8'h00, 0));
		pending_cmds.push_back(make_cmd(ACT_DELETE, 8'h11, 8'hff, 8'hff, 0));
		pending_cmds.push_back(make_cmd(ACT_NONE, 8'hff, 8'hff, 8'hff, 0));
		pending_cmds.push_back(make_cmd(ACT_PUSH, 8'h00, 8'h00, 8'h00, 0));
		pending_cmds.push_back(make_cmd(ACT_PUSH, 8'hff, 8'hff, 8'hff, 0));
		pending_cmds.push_back(make_cmd(ACT_PUSH, 8'ha5, 8'h5a, 8'hc3, 0));
		pending_cmds.push_back(make_cmd(ACT_DELETE, 8'hff, 8'h00, 8'h00, 0));
		pending_cmds.push_back(make_cmd(ACT_DELETE, 8'ha5, 8'h00, 8'h00, 0));
		pending_cmds.push_back(make_cmd(ACT_DELETE, 8'h77, 8'h00, 8'h00, 0));
		pending_cmds.push_back(make_cmd(ACT_POP, 8'h00, 8'h00, 8'h00, 0));
		// fill to capacity with a repeated key, then overflow
		for (int i = 0; i < DEPTH; i++)
			pending_cmds.push_back(make_cmd(ACT_PUSH, (i % 4 == 0) ? 8'h3c : 8'(i),
				8'(i * 17), 8'(255 - i), 0));
		pending_cmds.push_back(make_cmd(ACT_PUSH, 8'h99, 8'h99, 8'h99, 0));
		pending_cmds.push_back(make_cmd(ACT_DELETE, 8'h3c, 8'h00, 8'h00, 0));
		pending_cmds.push_back(make_cmd(ACT_DELETE, 8'h0f, 8'h00, 8'h00, 0));
		pending_cmds.push_back(make_cmd(ACT_POP, 8'h00, 8'h00, 8'h00, 0));

		// random: stretches that lean toward push or toward pop/delete
		n_real  = 0;
		stretch = 0;
		push_bias = 50;
		while (n_real < NumRandom) begin
			if (stretch == 0) begin
				stretch   = $urandom_range(10, 50);
				push_bias = $urandom_range(15, 85);
			end
			stretch--;
			if (n_real < NumRandom / 4)
				pct = 0;
			else if (n_real < NumRandom / 2)
				pct = 83;
			else if (n_real < 3 * NumRandom / 4)
				pct = 0;
			else
				pct = 36;
			pick = $urandom_range(99);
			if (pick < 3)
				act = ACT_NONE;
			else if ($urandom_range(99) < push_bias)
				act = ACT_PUSH;
			else if ($urandom_range(1) == 0)
				act = ACT_POP;
			else
				act = ACT_DELETE;
			// keep most keys in a narrow set so deletes find matches
			key = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(7));
			pending_cmds.push_back(make_cmd(act, key, 8'($urandom_range(255)),
				8'($urandom_range(255)), pct));
			if (act != ACT_NONE)
				n_real++;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || start || expected_results.size() != 0)
			@(negedge clk);
		repeat (2 * DEPTH + 4) @(posedge clk);

		$display("Sent %0d commands, checked %0d results, %0d mismatches.",
			cmds_sent, results_seen, mismatches);
		$display("Status coverage: full %0d, empty %0d, key not found %0d.",
			seen_full, seen_empty, seen_notfound);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("Timeout with %0d results outstanding.", expected_results.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: files.f
sv/kis_pkg.sv
sv/kis_mem.sv
sv/kis_seq.sv
sv/keyed_item_stack.sv
sv/kis_checker.sv
verif/keyed_item_stack_tb.sv
